### rtl/tpr_pkg.sv
// Package for the two-tap time-of-flight ratio distance core.
// Holds sizes, the configuration register codes and the structs shared by the modules.
// Depends on nothing.
package tpr_pkg;

    // Pixel flag store depth and its address width
    localparam int MAX_PIXELS = 131072;
    localparam int FLAG_AW    = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

    // Field widths
    localparam int IDX_W  = 17;
    localparam int TAP_W  = 16;
    localparam int SUM_W  = TAP_W + 1;
    localparam int DIST_W = 16;
    localparam int AMP_W  = 16;

    // Stream packing, padded to whole bytes
    localparam int IN_BITS     = IDX_W + 2 * TAP_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = DIST_W + AMP_W + 1;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // Re-centring point and optional sample shift
    localparam logic [TAP_W-1:0] RECENTER  = TAP_W'(2048);
    localparam int               SHIFT_AMT = 4;

    // Divider: quotient bits (one per cell) and partial remainder width
    localparam int QUO_W = DIST_W;
    localparam int NUM_W = 2 * TAP_W + 2;

    typedef logic [FLAG_AW-1:0] t_flag_addr;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIXEL_MASK   = 3'd0,
        CFG_SAMPLE_SHIFT = 3'd1,
        CFG_PHASE_OFFSET = 3'd2,
        CFG_MAX_DISTANCE = 3'd3,
        CFG_LOW_AMP_CODE = 3'd4,
        CFG_MIN_AMP      = 3'd5,
        CFG_HYST_WIDTH   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [TAP_W-1:0]        pixel_mask;
        logic                    sample_shift;
        logic signed [DIST_W-1:0] phase_offset;
        logic [DIST_W-1:0]       max_distance;
        logic [DIST_W-1:0]       low_amp_code;
        logic [SUM_W-1:0]        min_amp;
        logic [AMP_W-1:0]        hyst_width;
    } t_cfg;

    // One pixel as it walks down the divider chain
    typedef struct packed {
        logic              valid;
        logic [NUM_W-1:0]  rem;
        logic [NUM_W-1:0]  dsh;
        logic [QUO_W-1:0]  quo;
        logic              low;
        logic [AMP_W-1:0]  amp;
        logic              ok;
    } t_cell;

    // Result item, last field in the lowest bits
    typedef struct packed {
        logic              ok;
        logic [AMP_W-1:0]  amp;
        logic [DIST_W-1:0] distance;
    } t_res;

endpackage

### rtl/tpr_front.sv
// Front end: sample conditioning, pixel flag store with hysteresis, product stage.
// Feeds the first divider cell. Depends on tpr_pkg.
module tpr_front import tpr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_acc,
    input  logic [IDX_W-1:0] i_idx,
    input  logic [TAP_W-1:0] i_tap_a,
    input  logic [TAP_W-1:0] i_tap_b,
    input  t_cfg             i_cfg,
    output logic             o_busy,
    output t_cell            o_cell
);

    // Mask, optional shift, absolute distance from the centre
    function automatic logic [TAP_W-1:0] centred_abs(input logic [TAP_W-1:0] raw,
                                                     input logic [TAP_W-1:0] mask,
                                                     input logic             shift);
        logic [TAP_W-1:0] v;
        v = raw & mask;
        if (shift) begin
            v = v >> SHIFT_AMT;
        end
        return (v <= RECENTER) ? (RECENTER - v) : (v - RECENTER);
    endfunction

    localparam t_flag_addr CLR_LAST = t_flag_addr'(MAX_PIXELS - 1);

    logic              r_mem [MAX_PIXELS];
    logic              r_rd;

    logic              r_busy;
    t_flag_addr        r_clr_cnt;

    logic              r_s0_valid;
    logic [IDX_W-1:0]  r_s0_idx;
    logic [TAP_W-1:0]  r_s0_mb;
    logic [SUM_W-1:0]  r_s0_sum;
    logic              r_hit;
    logic              r_fwd;

    logic              r_s1_valid;
    logic [2*TAP_W-1:0] r_s1_prod;
    logic [SUM_W-1:0]  r_s1_sum;
    logic              r_s1_low;
    logic [AMP_W-1:0]  r_s1_amp;
    logic              r_s1_ok;

    logic [TAP_W-1:0]  ma;
    logic [TAP_W-1:0]  mb;
    logic              qual_on;
    logic              in_range;
    logic              s0_wr;
    logic              prev;
    logic [SUM_W:0]    thresh;
    logic              ok;
    logic              mem_we;
    t_flag_addr        wr_addr;
    logic              wr_data;

    assign ma = centred_abs(i_tap_a, i_cfg.pixel_mask, i_cfg.sample_shift);
    assign mb = centred_abs(i_tap_b, i_cfg.pixel_mask, i_cfg.sample_shift);

    // Hysteresis on the pixel in stage 0; forward the flag written one transfer earlier
    always_comb begin
        qual_on  = (i_cfg.min_amp != '0);
        in_range = (32'(r_s0_idx) < 32'(MAX_PIXELS));
        s0_wr    = qual_on && in_range;
        prev     = in_range && (r_hit ? r_fwd : r_rd);
        thresh   = {1'b0, i_cfg.min_amp} + (SUM_W + 1)'(i_cfg.hyst_width);
        if (!qual_on) begin
            ok = 1'b1;
        end else if ({1'b0, r_s0_sum} > thresh) begin
            ok = 1'b1;
        end else if (r_s0_sum < i_cfg.min_amp) begin
            ok = 1'b0;
        end else begin
            ok = prev;
        end
    end

    // Flag store write port: clearing pass after reset, then flag updates
    always_comb begin
        mem_we  = r_busy || (i_en && r_s0_valid && s0_wr);
        wr_addr = r_busy ? r_clr_cnt : t_flag_addr'(r_s0_idx);
        wr_data = r_busy ? 1'b0 : ok;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_en) begin
            r_rd <= r_mem[t_flag_addr'(i_idx)];
        end
    end

    // Clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_cnt <= '0;
        end else if (r_busy) begin
            r_clr_cnt <= r_clr_cnt + t_flag_addr'(1);
            if (r_clr_cnt == CLR_LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Stage 0 and stage 1 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
        end else if (i_en) begin
            r_s0_valid <= i_acc;
            r_s0_idx   <= i_idx;
            r_s0_mb    <= mb;
            r_s0_sum   <= SUM_W'(ma) + SUM_W'(mb);
            r_hit      <= r_s0_valid && s0_wr && (i_idx == r_s0_idx);
            r_fwd      <= ok;

            r_s1_valid <= r_s0_valid;
            r_s1_prod  <= r_s0_mb * i_cfg.max_distance;
            r_s1_sum   <= r_s0_sum;
            r_s1_low   <= !ok || (r_s0_sum == '0);
            r_s1_amp   <= r_s0_sum[SUM_W-1] ? {AMP_W{1'b1}} : r_s0_sum[AMP_W-1:0];
            r_s1_ok    <= ok;
        end
    end

    // Numerator 2*b*max + sum, divisor 2*sum aligned to the top quotient bit
    always_comb begin
        o_cell.valid = r_s1_valid;
        o_cell.rem   = NUM_W'({r_s1_prod, 1'b0}) + NUM_W'(r_s1_sum);
        o_cell.dsh   = NUM_W'({r_s1_sum, 1'b0}) << (QUO_W - 1);
        o_cell.quo   = '0;
        o_cell.low   = r_s1_low;
        o_cell.amp   = r_s1_amp;
        o_cell.ok    = r_s1_ok;
    end

    assign o_busy = r_busy;

endmodule

### rtl/tpr_div_cell.sv
// One cell of the restoring divider chain: settles one quotient bit per pixel.
// Hands its pixel to the next cell every advancing cycle. Depends on tpr_pkg.
module tpr_div_cell import tpr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_cell i_cell,
    output t_cell o_cell
);

    t_cell          r_cell;
    t_cell          n_cell;
    logic [NUM_W:0] diff;
    logic           ge;

    // Trial subtract of the aligned divisor
    always_comb begin
        diff         = {1'b0, i_cell.rem} - {1'b0, i_cell.dsh};
        ge           = !diff[NUM_W];
        n_cell       = i_cell;
        n_cell.rem   = ge ? diff[NUM_W-1:0] : i_cell.rem;
        n_cell.dsh   = i_cell.dsh >> 1;
        n_cell.quo   = {i_cell.quo[QUO_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

### rtl/tpr_out.sv
// Output stage: phase offset, clamp, low-amplitude substitution, output register and skid.
// Drives the pipeline advance. Depends on tpr_pkg.
module tpr_out import tpr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell      i_cell,
    input  t_cfg       i_cfg,
    input  logic       i_tready,
    output logic       o_en,
    output logic       o_tvalid,
    output t_res       o_res
);

    logic               r_out_valid;
    t_res               r_out;
    logic               r_skid_valid;
    t_res               r_skid;

    logic signed [DIST_W+1:0] d;
    t_res                     res;

    // Quotient plus signed offset, clamped to the unsigned distance range
    always_comb begin
        d = $signed({2'b00, i_cell.quo}) +
            $signed({{2{i_cfg.phase_offset[DIST_W-1]}}, i_cfg.phase_offset});
        res.ok  = i_cell.ok;
        res.amp = i_cell.amp;
        if (i_cell.low) begin
            res.distance = i_cfg.low_amp_code;
        end else if (d[DIST_W+1]) begin
            res.distance = '0;
        end else if (d[DIST_W]) begin
            res.distance = {DIST_W{1'b1}};
        end else begin
            res.distance = d[DIST_W-1:0];
        end
    end

    // Output register with a one-entry skid behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_tready) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out        <= res;
                r_out_valid  <= i_cell.valid;
            end
        end else if (i_cell.valid && !r_skid_valid) begin
            r_skid       <= res;
            r_skid_valid <= 1'b1;
        end
    end

    assign o_en     = !r_skid_valid;
    assign o_tvalid = r_out_valid;
    assign o_res    = r_out;

endmodule

### rtl/tof_pulse_ratio_distance_core.sv
// Two-tap pulsed time-of-flight distance core: one pixel in, one distance result out.
// Built from tpr_front, a chain of tpr_div_cell and tpr_out. Depends on tpr_pkg.
//
// The core takes one pixel per clock while input ready is high and returns one result per
// pixel, in order. On its way to output valid the transfer loads a conditioning/flag-lookup
// stage, followed by a product stage, one divider cell per distance bit (16 cells), and the
// output register; the divider cells form a pipeline, so a new pixel enters every cycle unless
// the output skid is full or the clearing pass runs. The per-pixel hysteresis flags sit in a
// one-bit-wide memory read at the input transfer and written as the pixel leaves the first
// stage, with forwarding between neighboring pixels of the same index. After reset the core
// clears all MAX_PIXELS (131072) entries of that memory one entry per cycle; input ready
// stays low during the clearing pass while configuration writes are taken. Configuration is
// to be written while the core holds no pixels; the core itself does not enforce this.
module tof_pulse_ratio_distance_core import tpr_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // Pixel stream in
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,  // pixel_index[16:0], tap_a_raw[32:17],
                                               // tap_b_raw[48:33], zero pad
    // Result stream out
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata   // distance[15:0], amplitude[31:16],
                                               // signal_ok[32], zero pad
);

    t_cfg  r_cfg;
    logic  en;
    logic  busy;
    logic  acc;
    t_res  res;
    t_cell w_chain [QUO_W+1];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_mask   <= TAP_W'(4095);
            r_cfg.sample_shift <= 1'b0;
            r_cfg.phase_offset <= '0;
            r_cfg.max_distance <= DIST_W'(30000);
            r_cfg.low_amp_code <= DIST_W'(65000);
            r_cfg.min_amp      <= '0;
            r_cfg.hyst_width   <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PIXEL_MASK:   r_cfg.pixel_mask   <= i_cfg_data[TAP_W-1:0];
                CFG_SAMPLE_SHIFT: r_cfg.sample_shift <= i_cfg_data[0];
                CFG_PHASE_OFFSET: r_cfg.phase_offset <= i_cfg_data[DIST_W-1:0];
                CFG_MAX_DISTANCE: r_cfg.max_distance <= i_cfg_data[DIST_W-1:0];
                CFG_LOW_AMP_CODE: r_cfg.low_amp_code <= i_cfg_data[DIST_W-1:0];
                CFG_MIN_AMP:      r_cfg.min_amp      <= i_cfg_data[SUM_W-1:0];
                CFG_HYST_WIDTH:   r_cfg.hyst_width   <= i_cfg_data[AMP_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = en && !busy;
    assign acc         = i_s_tvalid && o_s_tready;

    tpr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_acc   (acc),
        .i_idx   (i_s_tdata[IDX_W-1:0]),
        .i_tap_a (i_s_tdata[IDX_W+TAP_W-1:IDX_W]),
        .i_tap_b (i_s_tdata[IDX_W+2*TAP_W-1:IDX_W+TAP_W]),
        .i_cfg   (r_cfg),
        .o_busy  (busy),
        .o_cell  (w_chain[0])
    );

    // Divider chain, one quotient bit per cell
    for (genvar k = 0; k < QUO_W; k++) begin : g_cell
        tpr_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_cell  (w_chain[k]),
            .o_cell  (w_chain[k+1])
        );
    end

    tpr_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cell   (w_chain[QUO_W]),
        .i_cfg    (r_cfg),
        .i_tready (i_m_tready),
        .o_en     (en),
        .o_tvalid (o_m_tvalid),
        .o_res    (res)
    );

    assign o_m_tdata = OUT_TDATA_W'(res);

endmodule

### rtl/tpr_checker.sv
// Port-level checks for tof_pulse_ratio_distance_core, attached by the bind at the end.
// Depends on tpr_pkg.
module tpr_checker import tpr_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   o_s_tready,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int MAX_INFLIGHT = 20;

    logic [5:0] r_cnt;
    logic [5:0] n_cnt;

    // Pixels accepted and not yet delivered
    always_comb begin
        n_cnt = r_cnt;
        if (i_s_tvalid && o_s_tready) begin
            n_cnt = n_cnt + 6'd1;
        end
        if (o_m_tvalid && i_m_tready) begin
            n_cnt = n_cnt - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> r_cnt != 6'd0)
        else $error("result with no pixel in flight");

    a_inflight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 6'(MAX_INFLIGHT))
        else $error("more pixels in flight than pipeline depth");

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_tready)
        else $error("input ready during flag clearing pass");

endmodule

bind tof_pulse_ratio_distance_core tpr_checker u_tpr_checker (.*);
